### rtl/core/smss_pkg.sv
// smss_pkg: shared constants, codes and types of the sorted multiset store
// no dependencies; imported by the cell, the top level, both checkers and the testbench
`default_nettype none

package smss_pkg;

    // storage geometry
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNTO_W   = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READOUT = 2'd2;

    // cell operation codes
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    // broadcast control to every cell of the row
    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### rtl/core/sorted_multiset_store_unit.sv
// sorted_multiset_store_unit: top level, a row of smss_cell storage cells
// plus count, readout sequencer and result registers; uses smss_pkg
`default_nettype none

// A request is taken when start is high and busy is low. Insert, delete and
// the unused code update the store at the accepting edge, and the single
// result strobes on o_strobe in the following cycle, so such requests may
// be issued every cycle. A readout of a non-empty store rotates the cell row
// once per stored entry: busy stays high while the row rotates, and one
// distinct value strobes per run of equal entries,
// the last one marked by o_last. A readout of an empty store gives one result
// in the next cycle without going busy. Results are shown for one cycle only
// and must be taken as they come; the store gives no back-pressure path.
module sorted_multiset_store_unit import smss_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic [REQ_W-1:0]         i_req_type,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          busy,
    output logic                          o_strobe,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic                          o_value_valid,
    output logic                          o_last,
    output logic                          o_removed,
    output logic                          o_rejected,
    output logic [CNTO_W-1:0]             o_entry_count
);

    logic [CNT_W-1:0]  r_count;
    logic              r_scan;
    logic [IDX_W-1:0]  r_idx;
    logic              r_strobe;
    logic [DATA_W-1:0] r_out_value;
    logic              r_value_valid;
    logic              r_last;
    logic              r_removed;
    logic              r_rejected;

    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_tail;
    t_cell_ctrl        w_ctrl;
    logic              w_accept;
    logic              w_full;
    logic              w_found;
    logic              w_scan_last;
    logic              w_emit;

    assign busy     = r_scan;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_found  = |w_eq;

    // broadcast control for the cell row
    always_comb begin
        w_ctrl.value = i_value;
        w_ctrl.op    = OP_HOLD;
        if (r_scan) begin
            w_ctrl.op = OP_ROTATE;
        end else if (w_accept) begin
            if ((i_req_type == REQ_INSERT) && !w_full) w_ctrl.op = OP_INSERT;
            if ((i_req_type == REQ_DELETE) && w_found) w_ctrl.op = OP_DELETE;
        end
    end

    // row of cells, each wired to both neighbors
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic              w_prev_lt;
        logic [DATA_W-1:0] w_prev_value;
        logic [DATA_W-1:0] w_next_value;

        assign w_occ[j] = (r_count > CNT_W'(j));

        if (j == 0) begin : g_first
            assign w_prev_lt    = 1'b1;
            assign w_prev_value = w_entry[0];
        end else begin : g_inner_prev
            assign w_prev_lt    = w_lt[j-1];
            assign w_prev_value = w_entry[j-1];
        end

        if (j == CAPACITY - 1) begin : g_final
            assign w_next_value = w_entry[j];
            assign w_tail[j]    = w_occ[j];
        end else begin : g_inner_next
            assign w_next_value = w_entry[j+1];
            assign w_tail[j]    = w_occ[j] && (r_count <= CNT_W'(j + 1));
        end

        smss_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (w_occ[j]),
            .i_tail       (w_tail[j]),
            .i_prev_lt    (w_prev_lt),
            .i_prev_value (w_prev_value),
            .i_next_value (w_next_value),
            .i_head_value (w_entry[0]),
            .o_lt         (w_lt[j]),
            .o_eq         (w_eq[j]),
            .o_value      (w_entry[j])
        );
    end

    // readout: the head emits the final entry of each run of equal values
    assign w_scan_last = (r_idx == IDX_W'(r_count - CNT_W'(1)));
    assign w_emit      = (w_entry[0] != w_entry[1]) || w_scan_last;

    // control state: count, readout sequencer, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_scan   <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (r_scan) begin
                r_strobe <= w_emit;
                r_idx    <= r_idx + IDX_W'(1);
                if (w_scan_last) r_scan <= 1'b0;
            end else if (w_accept) begin
                r_strobe <= 1'b1;
                case (i_req_type)
                    REQ_INSERT: begin
                        if (!w_full) r_count <= r_count + CNT_W'(1);
                    end
                    REQ_DELETE: begin
                        if (w_found) r_count <= r_count - CNT_W'(1);
                    end
                    REQ_READOUT: begin
                        if (r_count != '0) begin
                            r_strobe <= 1'b0;
                            r_scan   <= 1'b1;
                            r_idx    <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_scan) begin
            r_out_value   <= w_entry[0];
            r_value_valid <= 1'b1;
            r_last        <= w_scan_last;
            r_removed     <= 1'b0;
            r_rejected    <= 1'b0;
        end else begin
            r_out_value   <= '0;
            r_value_valid <= 1'b0;
            r_last        <= 1'b1;
            r_removed     <= (i_req_type == REQ_DELETE) && w_found;
            r_rejected    <= (i_req_type == REQ_INSERT) && w_full;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_value   = r_out_value;
    assign o_value_valid = r_value_valid;
    assign o_last        = r_last;
    assign o_removed     = r_removed;
    assign o_rejected    = r_rejected;
    assign o_entry_count = CNTO_W'(r_count);

endmodule

`default_nettype wire

### rtl/core/smss_cell.sv
// smss_cell: one storage cell of the sorted row, compares against the
// broadcast value and shifts to or from its neighbors; uses smss_pkg
`default_nettype none

module smss_cell import smss_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic              i_occ,
    input  wire logic              i_tail,
    input  wire logic              i_prev_lt,
    input  wire logic [DATA_W-1:0] i_prev_value,
    input  wire logic [DATA_W-1:0] i_next_value,
    input  wire logic [DATA_W-1:0] i_head_value,
    output logic                   o_lt,
    output logic                   o_eq,
    output logic [DATA_W-1:0]      o_value
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // signed compare against the broadcast value
    assign o_lt    = i_occ && ($signed(r_value) < $signed(i_ctrl.value));
    assign o_eq    = i_occ && (r_value == i_ctrl.value);
    assign o_value = r_value;

    // next content: keep, open a gap, close a gap or rotate toward the head
    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_HOLD: n_value = r_value;
            OP_INSERT: begin
                if (!o_lt) n_value = i_prev_lt ? i_ctrl.value : i_prev_value;
            end
            OP_DELETE: begin
                if (!o_lt) n_value = i_next_value;
            end
            OP_ROTATE: n_value = i_tail ? i_head_value : i_next_value;
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

### rtl/core/smss_checker.sv
// smss_checker: port-level assertions for sorted_multiset_store_unit,
// attached by the bind at the end of this file; uses smss_pkg
`default_nettype none

module smss_checker import smss_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     start,
    input wire logic [REQ_W-1:0]         i_req_type,
    input wire logic                     busy,
    input wire logic                     o_strobe,
    input wire logic                     o_value_valid,
    input wire logic                     o_last,
    input wire logic                     o_removed,
    input wire logic                     o_rejected,
    input wire logic [CNTO_W-1:0]        o_entry_count
);

    // a non-readout transfer answers with one final result next cycle
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type != REQ_READOUT)) |=> (o_strobe && o_last))
        else $error("insert or delete gave no final result");

    // a readout value never carries delete or insert flags
    a_value_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_value_valid) |-> (!o_removed && !o_rejected))
        else $error("readout value carries status flags");

    // a refused insert only happens on a full store
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rejected) |-> (o_entry_count == CNTO_W'(CAPACITY)))
        else $error("insert refused below capacity");

    // a result without a value always closes its request
    a_novalue_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_value_valid) |-> o_last)
        else $error("valueless result not marked last");

    // more readout values follow only while the store is still busy
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_value_valid && !o_last) |-> busy)
        else $error("readout continues while not busy");

endmodule

bind sorted_multiset_store_unit smss_checker u_smss_checker (.*);

`default_nettype wire

### sim/smss_result_checker.sv
`timescale 1ns / 1ps
// smss_result_checker: watches the request and result channels of the sorted
// multiset store, predicts every result and compares it; uses smss_pkg

module smss_result_checker import smss_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_strobe,
    input  logic signed [DATA_W-1:0] i_out_value,
    input  logic                     i_value_valid,
    input  logic                     i_last,
    input  logic                     i_removed,
    input  logic                     i_rejected,
    input  logic [CNTO_W-1:0]        i_entry_count,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     value_valid;
        logic                     last;
        logic                     removed;
        logic                     rejected;
        logic [CNTO_W-1:0]        entry_count;
    } t_store_reply;

    // predicted contents of the store, ascending, duplicates kept
    logic signed [DATA_W-1:0] mset[$];
    // replies owed by the store, oldest first
    t_store_reply owed_replies[$];
    t_store_reply want;
    int fails = 0;

    task automatic compare_field(input string name, input logic signed [63:0] exp_val,
                                 input logic signed [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fails++;
        end
    endtask

    // apply one accepted request to the predicted store and queue its replies
    task automatic update_multiset(input logic [REQ_W-1:0] req,
                                   input logic signed [DATA_W-1:0] val);
        int pos;
        bit listed;
        t_store_reply r;
        pos    = 0;
        listed = 1'b0;
        r      = '0;
        case (req)
            REQ_INSERT: begin
                if (mset.size() >= CAPACITY) begin
                    r.rejected = 1'b1;
                end else begin
                    while (pos < mset.size() && mset[pos] < val) pos++;
                    mset.insert(pos, val);
                end
            end
            REQ_DELETE: begin
                while (pos < mset.size() && mset[pos] != val) pos++;
                if (pos < mset.size()) begin
                    mset.delete(pos);
                    r.removed = 1'b1;
                end
            end
            REQ_READOUT: begin
                // one reply per run of equal entries, last on the run at the tail
                for (int i = 0; i < mset.size(); i++) begin
                    if (i == 0 || mset[i] != mset[i-1]) begin
                        r             = '0;
                        r.out_value   = mset[i];
                        r.value_valid = 1'b1;
                        r.last        = (mset[i] == mset[mset.size()-1]);
                        r.entry_count = CNTO_W'(mset.size());
                        owed_replies.push_back(r);
                        listed = 1'b1;
                    end
                end
            end
            default: begin
                // spare code leaves the store alone
            end
        endcase
        if (!listed) begin
            r.last        = 1'b1;
            r.entry_count = CNTO_W'(mset.size());
            owed_replies.push_back(r);
        end
    endtask

    // compare results first, then take in the new request transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mset.delete();
            owed_replies.delete();
        end else begin
            if (i_strobe) begin
                if (owed_replies.size() == 0) begin
                    $error("result with no request outstanding: out_value %0d", i_out_value);
                    fails++;
                end else begin
                    want = owed_replies.pop_front();
                    compare_field("out_value", want.out_value, i_out_value);
                    compare_field("value_valid", {63'd0, want.value_valid},
                                  {63'd0, i_value_valid});
                    compare_field("last", {63'd0, want.last}, {63'd0, i_last});
                    compare_field("removed", {63'd0, want.removed}, {63'd0, i_removed});
                    compare_field("rejected", {63'd0, want.rejected}, {63'd0, i_rejected});
                    compare_field("entry_count", {57'd0, want.entry_count},
                                  {57'd0, i_entry_count});
                end
            end
            if (i_start && !i_busy) update_multiset(i_req_type, i_value);
        end
        o_pending    <= owed_replies.size();
        o_fail_count <= fails;
    end

endmodule

### sim/tb_sorted_multiset_store_unit.sv
`timescale 1ns / 1ps
// tb_sorted_multiset_store_unit: drives directed and random requests into the
// sorted multiset store; depends on smss_pkg, the store and smss_result_checker

module tb_sorted_multiset_store_unit;
    import smss_pkg::*;

    localparam logic [REQ_W-1:0]         REQ_SPARE = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    logic [REQ_W-1:0]         i_req_type = '0;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     busy;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_out_value;
    logic                     o_value_valid;
    logic                     o_last;
    logic                     o_removed;
    logic                     o_rejected;
    logic [CNTO_W-1:0]        o_entry_count;
    int                       fail_count;
    int                       pending;

    // up to 128 most recently inserted values, so that deletes often find a match
    logic signed [DATA_W-1:0] inserted_vals[$];

    always #1 i_clk = ~i_clk;

    sorted_multiset_store_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .busy          (busy),
        .o_strobe      (o_strobe),
        .o_out_value   (o_out_value),
        .o_value_valid (o_value_valid),
        .o_last        (o_last),
        .o_removed     (o_removed),
        .o_rejected    (o_rejected),
        .o_entry_count (o_entry_count)
    );

    smss_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_strobe      (o_strobe),
        .i_out_value   (o_out_value),
        .i_value_valid (o_value_valid),
        .i_last        (o_last),
        .i_removed     (o_removed),
        .i_rejected    (o_rejected),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // present one request and hold it until the transfer happens
    task automatic issue(input logic [REQ_W-1:0] req, input logic signed [DATA_W-1:0] val);
        start      <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        do @(posedge i_clk); while (busy);
        if (req == REQ_INSERT) begin
            inserted_vals.push_back(val);
            if (inserted_vals.size() > 128) void'(inserted_vals.pop_front());
        end
    endtask

    // mostly a small pool for duplicates, sometimes extremes or full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return $signed($urandom_range(0, 8)) - 4;
        if (roll == 6) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                default: return VAL_MAX - 1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_delete_value();
        if (inserted_vals.size() != 0 && $urandom_range(0, 9) < 6)
            return inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
        return pick_value();
    endfunction

    // random requests in bursts; steady phases never pause
    task automatic run_phase(input int count, input int ins_pct, input int del_pct,
                             input bit steady);
        int burst;
        int roll;
        logic [REQ_W-1:0] req;
        logic signed [DATA_W-1:0] val;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
                req = REQ_INSERT;
                val = pick_value();
            end else if (roll < ins_pct + del_pct) begin
                req = REQ_DELETE;
                val = pick_delete_value();
            end else if (roll < ins_pct + del_pct + 3) begin
                req = REQ_SPARE;
                val = $urandom();
            end else begin
                req = REQ_READOUT;
                val = $urandom();
            end
            issue(req, val);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if (!steady) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, duplicates, head, tail and only entry
        issue(REQ_READOUT, 32'sd0);
        issue(REQ_DELETE, 32'sd5);
        issue(REQ_SPARE, 32'sd0);
        issue(REQ_INSERT, 32'sd0);
        issue(REQ_INSERT, VAL_MAX);
        issue(REQ_INSERT, VAL_MIN);
        issue(REQ_INSERT, -32'sd1);
        issue(REQ_INSERT, 32'sd0);
        issue(REQ_INSERT, 32'sd0);
        issue(REQ_READOUT, 32'sd0);
        issue(REQ_DELETE, 32'sd7);
        issue(REQ_DELETE, VAL_MAX);
        issue(REQ_DELETE, VAL_MIN);
        issue(REQ_DELETE, 32'sd0);
        issue(REQ_READOUT, -32'sd1);
        issue(REQ_SPARE, VAL_MAX);
        issue(REQ_READOUT, $urandom());
        issue(REQ_DELETE, -32'sd1);
        issue(REQ_DELETE, 32'sd0);
        issue(REQ_DELETE, 32'sd0);
        issue(REQ_READOUT, 32'sd0);
        issue(REQ_INSERT, 32'sd1);
        issue(REQ_DELETE, 32'sd1);
        issue(REQ_READOUT, 32'sd0);
        start <= 1'b0;
        repeat (3) @(posedge i_clk);

        // fill to capacity and beyond, churn, drain, refill
        run_phase(130, 85, 7, 1'b0);
        run_phase(100, 45, 40, 1'b1);
        run_phase(120, 10, 80, 1'b0);
        run_phase(110, 85, 7, 1'b0);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_sorted_multiset_store_unit: clean");
        end else begin
            $display("tb_sorted_multiset_store_unit: errors");
        end
        $finish;
    end

    // watchdog well past the slowest correct run
    initial begin
        #1_000_000;
        $display("tb_sorted_multiset_store_unit: errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/smss_pkg.sv
rtl/core/smss_cell.sv
rtl/core/sorted_multiset_store_unit.sv
rtl/core/smss_checker.sv
sim/smss_result_checker.sv
sim/tb_sorted_multiset_store_unit.sv
